>>> design/pedal_swept_stereo_biquad_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the swept stereo biquad.
// Immediate-implication and next-cycle forms, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PEDAL_SWEPT_STEREO_BIQUAD_ASSERT_SVH
`define PEDAL_SWEPT_STEREO_BIQUAD_ASSERT_SVH

`define PSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/psb_pkg.sv
// ---------------------------------------------------------------------------
// psb_pkg
// Shared types and constants of the swept stereo biquad.
// ---------------------------------------------------------------------------
package psb_pkg;

    localparam int COEF_W   = 16;
    localparam int SAMPLE_W = 24;
    localparam int HIST_W   = 32;
    localparam int PROD_W   = COEF_W + HIST_W;
    localparam int QSHIFT   = 8;
    localparam int KINDS    = 5;

    localparam logic [7:0] ROW_TOP = 8'd255;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic [2:0] KIND_B0 = 3'd0;
    localparam logic [2:0] KIND_B1 = 3'd1;
    localparam logic [2:0] KIND_B2 = 3'd2;
    localparam logic [2:0] KIND_A1 = 3'd3;
    localparam logic [2:0] KIND_A2 = 3'd4;

    localparam logic signed [HIST_W-1:0] CLIP_HI = 32'sd8388607;
    localparam logic signed [HIST_W-1:0] CLIP_LO = -32'sd8388608;

    typedef struct packed {
        logic                       command;
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [7:0]                 pedal_position;
        logic [7:0]                 coef_row;
        logic [2:0]                 coef_kind;
        logic signed [COEF_W-1:0]   coef_value;
    } t_in_beat;

    typedef struct packed {
        logic                     channel_out;
        logic signed [HIST_W-1:0] sample_out;
    } t_out_beat;

    typedef struct packed {
        logic signed [HIST_W-1:0] x1;
        logic signed [HIST_W-1:0] x2;
        logic signed [HIST_W-1:0] y1;
        logic signed [HIST_W-1:0] y2;
    } t_hist;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_first;
        logic acc_sub;
    } t_mac_ctrl;

endpackage

>>> design/psb_stream_if.sv
// ---------------------------------------------------------------------------
// psb_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
interface psb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/psb_coef_mem.sv
// ---------------------------------------------------------------------------
// psb_coef_mem
// Coefficient memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module psb_coef_mem #(
    parameter int DEPTH = 1280
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]             i_wr_addr,
    input  logic signed [psb_pkg::COEF_W-1:0]    i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]             i_rd_addr,
    output logic signed [psb_pkg::COEF_W-1:0]    o_rd_data
);

    logic signed [psb_pkg::COEF_W-1:0] r_mem [DEPTH];
    logic signed [psb_pkg::COEF_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/psb_hist_mem.sv
// ---------------------------------------------------------------------------
// psb_hist_mem
// Per-channel filter history memory with valid bits and write bypass.
// ---------------------------------------------------------------------------
module psb_hist_mem #(
    parameter int CHANNELS = 2,
    parameter int IDX_W    = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output psb_pkg::t_hist        o_rd_data,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  psb_pkg::t_hist        i_wr_data
);

    psb_pkg::t_hist        r_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_valid;
    psb_pkg::t_hist        r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_data <= i_wr_data;
            end else if (!r_valid[i_rd_idx]) begin
                r_rd_data <= '0;
            end else begin
                r_rd_data <= r_mem[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/psb_mac.sv
// ---------------------------------------------------------------------------
// psb_mac
// Shared multiplier with a registered product and a 32-bit wrapping
// accumulator of floor-shifted Q8 terms.
// ---------------------------------------------------------------------------
module psb_mac (
    input  logic                                 i_clk,
    input  psb_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [psb_pkg::COEF_W-1:0]    i_coef,
    input  logic signed [psb_pkg::HIST_W-1:0]    i_operand,
    output logic signed [psb_pkg::HIST_W-1:0]    o_sum
);

    logic signed [psb_pkg::PROD_W-1:0] r_prod;
    logic signed [psb_pkg::HIST_W-1:0] r_acc;
    logic signed [psb_pkg::HIST_W-1:0] term;
    logic signed [psb_pkg::HIST_W-1:0] base;
    logic signed [psb_pkg::HIST_W-1:0] n_acc;

    always_comb begin
        term  = psb_pkg::HIST_W'(r_prod >>> psb_pkg::QSHIFT);
        base  = i_ctrl.acc_first ? '0 : r_acc;
        n_acc = i_ctrl.acc_sub ? (base - term) : (base + term);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= psb_pkg::PROD_W'(i_coef) * psb_pkg::PROD_W'(i_operand);
        end
        if (i_ctrl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_sum = n_acc;

endmodule

>>> design/pedal_swept_stereo_biquad.sv
// ---------------------------------------------------------------------------
// pedal_swept_stereo_biquad
// A sample's result beat reaches the output register after sequencer steps
// B0, B1, B2, A1, A2 and DONE; DONE waits until that register is free. The
// single shared multiplier (five products) and coefficient memory read port
// serialize samples; any input beat waits until the sample in flight moves on.
// Reset clears the sequencer, the output valid flag and the history valid
// bits; the coefficient memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module pedal_swept_stereo_biquad #(
    parameter int TABLE_ROWS = 256,
    parameter int CHANNELS   = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psb_stream_if.sink   i_in,
    psb_stream_if.source o_out
);

    `include "pedal_swept_stereo_biquad_assert.svh"

    localparam int DEPTH = TABLE_ROWS * psb_pkg::KINDS;
    localparam int CA_W  = $clog2(DEPTH);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] STEP_B0   = 3'd0;
    localparam logic [2:0] STEP_B1   = 3'd1;
    localparam logic [2:0] STEP_B2   = 3'd2;
    localparam logic [2:0] STEP_A1   = 3'd3;
    localparam logic [2:0] STEP_A2   = 3'd4;
    localparam logic [2:0] STEP_DONE = 3'd5;

    psb_pkg::t_in_beat  in_beat;
    psb_pkg::t_out_beat r_out;
    logic               r_out_valid;

    logic                                 r_busy;
    logic [2:0]                           r_step;
    logic                                 r_ch;
    logic signed [psb_pkg::SAMPLE_W-1:0]  r_x;
    logic [CA_W-1:0]                      r_base;

    logic                                 out_free;
    logic                                 fin_go;
    logic                                 adv;
    logic                                 ready;
    logic                                 accept;
    logic                                 is_coef;
    logic                                 ch_ok;
    logic                                 start;
    logic                                 coef_wr;
    logic [CA_W-1:0]                      wr_addr;
    logic [7:0]                           srow;
    logic [CA_W-1:0]                      srow_sat;
    logic [CA_W-1:0]                      start_base;
    logic                                 rd_en;
    logic [CA_W-1:0]                      rd_addr;
    logic signed [psb_pkg::COEF_W-1:0]    coef;
    psb_pkg::t_hist                       hist;
    psb_pkg::t_hist                       wb_hist;
    logic signed [psb_pkg::HIST_W-1:0]    operand;
    logic signed [psb_pkg::HIST_W-1:0]    sum;
    logic [psb_pkg::SAMPLE_W-1:0]         clipped;
    psb_pkg::t_mac_ctrl                   mac_ctrl;

    assign in_beat = i_in.data;

    always_comb begin
        out_free = !r_out_valid || o_out.ready;
        fin_go   = r_busy && (r_step == STEP_DONE) && out_free;
        adv      = r_busy && (r_step != STEP_DONE);
        ready    = !r_busy || fin_go;
        accept   = i_in.valid && ready;
        is_coef  = (in_beat.command == psb_pkg::CMD_COEF);
        ch_ok    = (32'(in_beat.channel) < CHANNELS);
        start    = accept && !is_coef && ch_ok;
        coef_wr  = accept && is_coef && (32'(in_beat.coef_row) < TABLE_ROWS)
                   && (in_beat.coef_kind <= psb_pkg::KIND_A2);
        wr_addr  = (CA_W'(in_beat.coef_row) << 2) + CA_W'(in_beat.coef_row)
                   + CA_W'(in_beat.coef_kind);
        srow     = psb_pkg::ROW_TOP - in_beat.pedal_position;
        srow_sat = (32'(srow) >= TABLE_ROWS) ? CA_W'(TABLE_ROWS - 1) : CA_W'(srow);
        start_base = (srow_sat << 2) + srow_sat;
        rd_en    = start || (adv && (r_step != STEP_A2));
        rd_addr  = start ? start_base : (r_base + CA_W'(r_step) + CA_W'(1));
    end

    assign i_in.ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_B0;
        end else if (start) begin
            r_busy <= 1'b1;
            r_step <= STEP_B0;
        end else if (fin_go) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_step <= r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_ch   <= in_beat.channel;
            r_x    <= in_beat.sample_in;
            r_base <= start_base;
        end
    end

    psb_coef_mem #(
        .DEPTH (DEPTH)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_wr_en   (coef_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_beat.coef_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (coef)
    );

    always_comb begin
        wb_hist.x1 = psb_pkg::HIST_W'(r_x);
        wb_hist.x2 = hist.x1;
        wb_hist.y1 = sum;
        wb_hist.y2 = hist.y1;
    end

    psb_hist_mem #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (start),
        .i_rd_idx  (IDX_W'(in_beat.channel)),
        .o_rd_data (hist),
        .i_wr_en   (fin_go),
        .i_wr_idx  (IDX_W'(r_ch)),
        .i_wr_data (wb_hist)
    );

    always_comb begin
        case (r_step)
            STEP_B0: operand = psb_pkg::HIST_W'(r_x);
            STEP_B1: operand = hist.x1;
            STEP_B2: operand = hist.x2;
            STEP_A1: operand = hist.y1;
            STEP_A2: operand = hist.y2;
            default: operand = psb_pkg::HIST_W'(r_x);
        endcase
        mac_ctrl.mul_en    = adv;
        mac_ctrl.acc_en    = (adv && (r_step != STEP_B0)) || fin_go;
        mac_ctrl.acc_first = (r_step == STEP_B1);
        mac_ctrl.acc_sub   = (r_step == STEP_A2) || (r_step == STEP_DONE);
    end

    psb_mac u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (mac_ctrl),
        .i_coef    (coef),
        .i_operand (operand),
        .o_sum     (sum)
    );

    always_comb begin
        if (sum > psb_pkg::CLIP_HI) begin
            clipped = psb_pkg::SAMPLE_W'(psb_pkg::CLIP_HI);
        end else if (sum < psb_pkg::CLIP_LO) begin
            clipped = psb_pkg::SAMPLE_W'(psb_pkg::CLIP_LO);
        end else begin
            clipped = sum[psb_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.channel_out <= r_ch;
            r_out.sample_out  <= {clipped, 8'd0};
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `PSB_ASSERT_IMP(a_no_accept_mid, i_clk, i_rst_n, r_busy && (r_step != STEP_DONE),
        !i_in.ready, "Input beat taken while the multiplier is busy.")
    `PSB_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, fin_go, o_out.valid,
        "Finished sample did not reach the output register.")
    `PSB_ASSERT_IMP(a_step_range, i_clk, i_rst_n, r_busy, r_step <= STEP_DONE,
        "Sequencer step out of range.")
    `PSB_ASSERT_NXT(a_start_step, i_clk, i_rst_n, start, r_busy && (r_step == STEP_B0),
        "Sample start did not restart the sequencer.")

endmodule
